### sv/pic_pkg.sv
package pic_pkg;

  localparam logic [2:0] OP_BUS_READ    = 3'd0;
  localparam logic [2:0] OP_BUS_WRITE   = 3'd1;
  localparam logic [2:0] OP_SET_LEVEL   = 3'd2;
  localparam logic [2:0] OP_QUERY       = 3'd3;
  localparam logic [2:0] OP_FORCE_CLAIM = 3'd4;

  localparam logic [2:0] RGN_NONE   = 3'd0;
  localparam logic [2:0] RGN_PRIO   = 3'd1;
  localparam logic [2:0] RGN_PEND   = 3'd2;
  localparam logic [2:0] RGN_ENABLE = 3'd3;
  localparam logic [2:0] RGN_CLAIM  = 3'd4;
  localparam logic [2:0] RGN_THRESH = 3'd5;

  localparam int PRIO_W   = 3;
  localparam int BITMAP_W = 32;

  typedef struct packed {
    logic [2:0]  operation;
    logic [21:0] offset;
    logic [31:0] write_data;
    logic [4:0]  source;
    logic [1:0]  target;
    logic        level;
  } pic_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        any_pending;
  } pic_rsp_t;

  typedef struct packed {
    logic [2:0]  region;
    logic [19:0] word;
  } pic_dec_t;

endpackage

### sv/pic_if.sv
interface pic_req_if;
  logic             valid;
  logic             ready;
  pic_pkg::pic_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pic_rsp_if;
  logic             valid;
  logic             ready;
  pic_pkg::pic_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/pic_decode.sv
module pic_decode #(
  parameter int SRC_COUNT       = 32,
  parameter int TGT_COUNT       = 4,
  parameter int PRIORITY_OFFSET = 0,
  parameter int PENDING_OFFSET  = 4096,
  parameter int ENABLE_OFFSET   = 8192,
  parameter int CLAIM_OFFSET    = 2097152
) (
  input  logic [21:0]       offset,
  input  logic              is_write,
  output pic_pkg::pic_dec_t dec
);
  import pic_pkg::*;

  localparam int WORDS = (SRC_COUNT + 31) / 32;

  localparam logic [31:0] PRIO_LO = 32'(PRIORITY_OFFSET);
  localparam logic [31:0] PRIO_HI = 32'(PRIORITY_OFFSET + SRC_COUNT * 4);
  localparam logic [31:0] PEND_LO = 32'(PENDING_OFFSET);
  localparam logic [31:0] PEND_HI = 32'(PENDING_OFFSET + WORDS * 4);
  localparam logic [31:0] EN_LO   = 32'(ENABLE_OFFSET);
  localparam logic [31:0] EN_HI   = 32'(ENABLE_OFFSET + TGT_COUNT * WORDS * 4);
  localparam logic [31:0] CLM_LO  = 32'(CLAIM_OFFSET);
  localparam logic [31:0] CLM_HI  = 32'(CLAIM_OFFSET + TGT_COUNT * 4);
  localparam logic [31:0] THR_HI  = 32'(CLAIM_OFFSET + TGT_COUNT * 8);

  logic [31:0] off_w;

  assign off_w = {10'd0, offset};

  always_comb begin
    dec.region = RGN_NONE;
    dec.word   = '0;
    if (off_w >= PRIO_LO && off_w < PRIO_HI) begin
      dec.region = RGN_PRIO;
      dec.word   = 20'((off_w - PRIO_LO) >> 2);
    end else if (!is_write && off_w >= PEND_LO && off_w < PEND_HI) begin
      dec.region = RGN_PEND;
      dec.word   = 20'((off_w - PEND_LO) >> 2);
    end else if (off_w >= EN_LO && off_w < EN_HI) begin
      dec.region = RGN_ENABLE;
      dec.word   = 20'((off_w - EN_LO) >> 2);
    end else if (off_w >= CLM_LO && off_w < CLM_HI) begin
      dec.region = RGN_CLAIM;
      dec.word   = 20'((off_w - CLM_LO) >> 2);
    end else if (off_w >= CLM_HI && off_w < THR_HI) begin
      dec.region = RGN_THRESH;
      dec.word   = 20'((off_w - CLM_HI) >> 2);
    end
  end

endmodule

### sv/platform_interrupt_controller_core.sv
// Interrupt controller with per-source priority and pending state and
// per-target enable masks, thresholds and claims.
// in_req carries one request: a bus read or write at a byte offset, a source
// level change, a best-source query for a target, or a forced claim.
// out_rsp returns exactly one response per request: read data (or the best
// source id for a query) and the any_pending flag for queries.
// Both channels use valid/ready; a transfer happens when both are high.
// A response is loaded into the output register in the finish state after
// the execute state, with a memory read state between them for a priority
// or enable read. A claim read with no current claim and a query scan
// sources 1 to SRC_COUNT - 1 through one shared priority compare, one
// source per cycle. One request is in flight at a time; in_req takes the
// next request the cycle after the response is loaded into that register.
// The output register holds its response while out_rsp.ready is low; a
// finished request then waits for the register and blocks new requests.
// After reset (rst_n low, synchronous) the priority and enable memories are
// cleared (SRC_COUNT and TGT_COUNT * words entries, where words =
// ceil(SRC_COUNT / 32)), one entry per cycle; in_req.ready stays low.
module platform_interrupt_controller_core #(
  parameter int SRC_COUNT       = 32,
  parameter int TGT_COUNT       = 4,
  parameter int PRIORITY_OFFSET = 0,
  parameter int PENDING_OFFSET  = 4096,
  parameter int ENABLE_OFFSET   = 8192,
  parameter int CLAIM_OFFSET    = 2097152
) (
  input logic        clk,
  input logic        rst_n,
  pic_req_if.sink    in_req,
  pic_rsp_if.source  out_rsp
);
  import pic_pkg::*;

  localparam int WORDS    = (SRC_COUNT + 31) / 32;
  localparam int SRC_W    = $clog2(SRC_COUNT);
  localparam int CNT_W    = $clog2(SRC_COUNT + 1);
  localparam int EN_DEPTH = TGT_COUNT * WORDS;
  localparam int EN_AW    = (EN_DEPTH > 1) ? $clog2(EN_DEPTH) : 1;
  localparam int TGT_W    = (TGT_COUNT > 1) ? $clog2(TGT_COUNT) : 1;
  localparam int WORD_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CLR_LEN  = (SRC_COUNT > EN_DEPTH) ? SRC_COUNT : EN_DEPTH;
  localparam int CLR_W    = $clog2(CLR_LEN);
  localparam int PEND_PAD = WORDS * BITMAP_W;
  localparam int PEND_IW  = $clog2(PEND_PAD);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_RDMEM = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  pic_req_t            req_r, req_nxt;
  logic [CLR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                eval_vld_r, eval_vld_nxt;
  logic [SRC_W-1:0]    eval_src_r, eval_src_nxt;
  logic [SRC_W-1:0]    best_r, best_nxt;
  logic [PRIO_W-1:0]   best_pri_r, best_pri_nxt;
  logic [TGT_W-1:0]    scan_tgt_r, scan_tgt_nxt;
  logic                scan_claim_r, scan_claim_nxt;
  logic                rd_en_r, rd_en_nxt;
  logic [31:0]         res_rd_r, res_rd_nxt;
  logic                res_any_r, res_any_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_rd_r, out_rd_nxt;
  logic                out_any_r, out_any_nxt;
  logic [SRC_COUNT-1:0] pend_r, pend_nxt;
  logic [SRC_W-1:0]    claim_r [TGT_COUNT];
  logic [SRC_W-1:0]    claim_nxt [TGT_COUNT];
  logic [PRIO_W-1:0]   thr_r [TGT_COUNT];
  logic [PRIO_W-1:0]   thr_nxt [TGT_COUNT];

  logic [PRIO_W-1:0]   prio_mem [SRC_COUNT];
  logic                prio_we;
  logic [SRC_W-1:0]    prio_waddr, prio_raddr;
  logic [PRIO_W-1:0]   prio_wdata, prio_rd_r;
  logic [31:0]         en_mem [EN_DEPTH];
  logic                en_we;
  logic [EN_AW-1:0]    en_waddr, en_raddr;
  logic [31:0]         en_wdata, en_rd_r;

  pic_dec_t            dec;
  logic [SRC_W-1:0]    dec_src;
  logic [EN_AW-1:0]    dec_en;
  logic [TGT_W-1:0]    dec_tgt;
  logic [WORD_W-1:0]   dec_pw;
  logic [PEND_IW-1:0]  pend_base;
  logic [SRC_W-1:0]    req_src;
  logic [TGT_W-1:0]    req_tgt;
  logic                src_ok, tgt_ok;
  logic [PEND_PAD-1:0] pend_pad;
  logic                issue, hit;

  pic_decode #(
    .SRC_COUNT       (SRC_COUNT),
    .TGT_COUNT       (TGT_COUNT),
    .PRIORITY_OFFSET (PRIORITY_OFFSET),
    .PENDING_OFFSET  (PENDING_OFFSET),
    .ENABLE_OFFSET   (ENABLE_OFFSET),
    .CLAIM_OFFSET    (CLAIM_OFFSET)
  ) u_decode (
    .offset   (req_r.offset),
    .is_write (req_r.operation == OP_BUS_WRITE),
    .dec      (dec)
  );

  assign dec_src   = dec.word[SRC_W-1:0];
  assign dec_en    = dec.word[EN_AW-1:0];
  assign dec_tgt   = dec.word[TGT_W-1:0];
  assign dec_pw    = dec.word[WORD_W-1:0];
  assign pend_base = PEND_IW'({dec_pw, 5'd0});
  assign req_src   = SRC_W'(req_r.source);
  assign req_tgt   = TGT_W'(req_r.target);
  assign src_ok    = (req_r.source != 5'd0) && (32'(req_r.source) < 32'(SRC_COUNT));
  assign tgt_ok    = 32'(req_r.target) < 32'(TGT_COUNT);
  assign pend_pad  = PEND_PAD'(pend_r);

  assign in_req.ready                = (state_r == ST_IDLE);
  assign out_rsp.valid               = out_valid_r;
  assign out_rsp.payload.read_data   = out_rd_r;
  assign out_rsp.payload.any_pending = out_any_r;

  assign issue = scan_cnt_r != CNT_W'(SRC_COUNT);
  assign hit   = eval_vld_r && pend_r[eval_src_r] && en_rd_r[5'(eval_src_r)] &&
                 (prio_rd_r > thr_r[scan_tgt_r]) && (prio_rd_r > best_pri_r);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    clr_cnt_nxt    = clr_cnt_r;
    scan_cnt_nxt   = scan_cnt_r;
    eval_vld_nxt   = eval_vld_r;
    eval_src_nxt   = eval_src_r;
    best_nxt       = best_r;
    best_pri_nxt   = best_pri_r;
    scan_tgt_nxt   = scan_tgt_r;
    scan_claim_nxt = scan_claim_r;
    rd_en_nxt      = rd_en_r;
    res_rd_nxt     = res_rd_r;
    res_any_nxt    = res_any_r;
    out_valid_nxt  = out_valid_r;
    out_rd_nxt     = out_rd_r;
    out_any_nxt    = out_any_r;
    pend_nxt       = pend_r;
    claim_nxt      = claim_r;
    thr_nxt        = thr_r;
    prio_we        = 1'b0;
    prio_waddr     = dec_src;
    prio_wdata     = req_r.write_data[PRIO_W-1:0];
    prio_raddr     = dec_src;
    en_we          = 1'b0;
    en_waddr       = dec_en;
    en_wdata       = req_r.write_data;
    en_raddr       = dec_en;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        prio_waddr = clr_cnt_r[SRC_W-1:0];
        prio_wdata = '0;
        prio_we    = 32'(clr_cnt_r) < 32'(SRC_COUNT);
        en_waddr   = clr_cnt_r[EN_AW-1:0];
        en_wdata   = '0;
        en_we      = 32'(clr_cnt_r) < 32'(EN_DEPTH);
        if (clr_cnt_r == CLR_W'(CLR_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          req_nxt   = in_req.payload;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt   = ST_FIN;
        res_rd_nxt  = '0;
        res_any_nxt = 1'b0;
        unique case (req_r.operation)
          OP_BUS_READ: begin
            unique case (dec.region)
              RGN_PRIO: begin
                if (dec_src != '0) begin
                  rd_en_nxt = 1'b0;
                  state_nxt = ST_RDMEM;
                end
              end
              RGN_PEND: res_rd_nxt = pend_pad[pend_base +: BITMAP_W];
              RGN_ENABLE: begin
                rd_en_nxt = 1'b1;
                state_nxt = ST_RDMEM;
              end
              RGN_CLAIM: begin
                if (claim_r[dec_tgt] != '0) begin
                  res_rd_nxt = 32'(claim_r[dec_tgt]);
                end else begin
                  scan_cnt_nxt   = CNT_W'(1);
                  eval_vld_nxt   = 1'b0;
                  best_nxt       = '0;
                  best_pri_nxt   = '0;
                  scan_tgt_nxt   = dec_tgt;
                  scan_claim_nxt = 1'b1;
                  state_nxt      = ST_SCAN;
                end
              end
              RGN_THRESH: res_rd_nxt = 32'(thr_r[dec_tgt]);
              default: ;
            endcase
          end
          OP_BUS_WRITE: begin
            unique case (dec.region)
              RGN_PRIO:   prio_we = dec_src != '0;
              RGN_ENABLE: en_we = 1'b1;
              RGN_CLAIM: begin
                if (claim_r[dec_tgt] != '0 &&
                    req_r.write_data == 32'(claim_r[dec_tgt])) begin
                  claim_nxt[dec_tgt] = '0;
                end
              end
              RGN_THRESH: thr_nxt[dec_tgt] = req_r.write_data[PRIO_W-1:0];
              default: ;
            endcase
          end
          OP_SET_LEVEL: begin
            if (src_ok) begin
              pend_nxt[req_src] = req_r.level;
            end
          end
          OP_QUERY: begin
            if (tgt_ok) begin
              scan_cnt_nxt   = CNT_W'(1);
              eval_vld_nxt   = 1'b0;
              best_nxt       = '0;
              best_pri_nxt   = '0;
              scan_tgt_nxt   = req_tgt;
              scan_claim_nxt = 1'b0;
              state_nxt      = ST_SCAN;
            end
          end
          OP_FORCE_CLAIM: begin
            if (tgt_ok && src_ok) begin
              claim_nxt[req_tgt] = req_src;
              pend_nxt[req_src]  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_RDMEM: begin
        res_rd_nxt = rd_en_r ? en_rd_r : 32'(prio_rd_r);
        state_nxt  = ST_FIN;
      end
      ST_SCAN: begin
        prio_raddr   = scan_cnt_r[SRC_W-1:0];
        en_raddr     = EN_AW'(int'(scan_tgt_r) * WORDS + int'(scan_cnt_r >> 5));
        eval_vld_nxt = issue;
        eval_src_nxt = scan_cnt_r[SRC_W-1:0];
        if (issue) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (hit) begin
          best_nxt     = eval_src_r;
          best_pri_nxt = prio_rd_r;
        end
        if (!issue && !eval_vld_r) begin
          res_rd_nxt  = 32'(best_r);
          res_any_nxt = !scan_claim_r && (best_r != '0);
          if (scan_claim_r && best_r != '0) begin
            claim_nxt[scan_tgt_r] = best_r;
            pend_nxt[best_r]      = 1'b0;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_any_nxt   = res_any_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[prio_waddr] <= prio_wdata;
    end
    prio_rd_r <= prio_mem[prio_raddr];
  end

  always_ff @(posedge clk) begin
    if (en_we) begin
      en_mem[en_waddr] <= en_wdata;
    end
    en_rd_r <= en_mem[en_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      eval_vld_r   <= 1'b0;
      scan_cnt_r   <= '0;
      scan_claim_r <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_r       <= '0;
      for (int t = 0; t < TGT_COUNT; t++) begin
        claim_r[t] <= '0;
        thr_r[t]   <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      eval_vld_r   <= eval_vld_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      scan_claim_r <= scan_claim_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
      claim_r      <= claim_nxt;
      thr_r        <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    eval_src_r <= eval_src_nxt;
    best_r     <= best_nxt;
    best_pri_r <= best_pri_nxt;
    scan_tgt_r <= scan_tgt_nxt;
    rd_en_r    <= rd_en_nxt;
    res_rd_r   <= res_rd_nxt;
    res_any_r  <= res_any_nxt;
    out_rd_r   <= out_rd_nxt;
    out_any_r  <= out_any_nxt;
  end

endmodule
